[hw/rtl/ptc_pkg.sv]
// Package: shared types and constants for the PTP transmit timestamp classifier.
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

    localparam int unsigned PosWidth = 7;
    localparam logic [PosWidth-1:0] PosMax = 7'd127;

    localparam logic [PosWidth-1:0] PosEtherHi = 7'd12;
    localparam logic [PosWidth-1:0] PosEtherLo = 7'd13;
    localparam logic [PosWidth-1:0] PosL2Start = 7'd14;

    localparam logic [PosWidth-1:0] PosV4Proto  = 7'd23;
    localparam logic [PosWidth-1:0] PosV4PortHi = 7'd36;
    localparam logic [PosWidth-1:0] PosV4PortLo = 7'd37;
    localparam logic [PosWidth-1:0] PosV4Start  = 7'd42;

    localparam logic [PosWidth-1:0] PosV6Proto  = 7'd20;
    localparam logic [PosWidth-1:0] PosV6PortHi = 7'd56;
    localparam logic [PosWidth-1:0] PosV6PortLo = 7'd57;
    localparam logic [PosWidth-1:0] PosV6Start  = 7'd62;

    localparam logic [PosWidth-1:0] FlagOffset = 7'd6;
    localparam logic [PosWidth-1:0] LastOffset = 7'd33;

    localparam logic [15:0] EtherTypePtp  = 16'h88F7;
    localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
    localparam logic [15:0] EtherTypeIpv6 = 16'h86DD;
    localparam logic [7:0]  ProtoUdp      = 8'd17;
    localparam logic [15:0] PortEvent     = 16'd319;
    localparam logic [15:0] PortGeneral   = 16'd320;
    localparam logic [7:0]  TypeMask      = 8'h0f;
    localparam int unsigned TwoStepBit    = 1;

    localparam logic [3:0] MsgSync     = 4'd0;
    localparam logic [3:0] MsgDelayReq = 4'd1;

    // frame encapsulation, settled at the EtherType low byte
    localparam logic [1:0] KindNone = 2'd0;
    localparam logic [1:0] KindL2   = 2'd1;
    localparam logic [1:0] KindIpv4 = 2'd2;
    localparam logic [1:0] KindIpv6 = 2'd3;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic       ptp_found;
        logic [3:0] msg_type;
        logic       two_step;
        logic       stamp_enable;
        logic       stamp_emit;
        logic       send_request;
    } out_item_t;

    // header state after the current byte has been applied
    typedef struct packed {
        logic       header_seen;
        logic [3:0] type_nibble;
        logic       two_step_flag;
    } frame_info_t;

endpackage

`default_nettype wire

[hw/rtl/ptc_stream_if.sv]
// Interface: valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps
`default_nettype none

interface ptc_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

[hw/rtl/ptc_frame_tracker.sv]
// Frame tracker: byte position and header field capture for one frame.
`timescale 1ns / 1ps
`default_nettype none

module ptc_frame_tracker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire ptc_pkg::in_item_t    item,
    output ptc_pkg::frame_info_t      info
);
    import ptc_pkg::*;

    logic [PosWidth-1:0] pos_reg, pos_next;
    logic [7:0]          ether_hi_reg, ether_hi_next;
    logic [1:0]          kind_reg, kind_next;
    logic                udp_reg, udp_next;
    logic                port_hi_ok_reg, port_hi_ok_next;
    logic                port_ok_reg, port_ok_next;
    logic [3:0]          nibble_reg, nibble_next;
    logic                flag_reg, flag_next;
    logic                seen_reg, seen_next;

    logic [PosWidth-1:0] start_pos;
    logic [PosWidth-1:0] proto_pos;
    logic [PosWidth-1:0] port_hi_pos;
    logic [PosWidth-1:0] port_lo_pos;
    logic [15:0]         ether_full;
    logic [7:0]          b;
    logic                qualifies;

    assign b          = item.frame_byte;
    assign ether_full = {ether_hi_reg, b};

    always_comb
    begin
        start_pos   = PosL2Start;
        proto_pos   = PosV4Proto;
        port_hi_pos = PosV4PortHi;
        port_lo_pos = PosV4PortLo;
        unique case (kind_reg)
            KindL2:
            begin
                start_pos = PosL2Start;
            end
            KindIpv4:
            begin
                start_pos = PosV4Start;
            end
            KindIpv6:
            begin
                start_pos   = PosV6Start;
                proto_pos   = PosV6Proto;
                port_hi_pos = PosV6PortHi;
                port_lo_pos = PosV6PortLo;
            end
            default:
            begin
                start_pos = PosL2Start;
            end
        endcase
    end

    assign qualifies = (kind_reg == KindL2) || (udp_reg && port_ok_reg);

    always_comb
    begin
        ether_hi_next   = ether_hi_reg;
        kind_next       = kind_reg;
        udp_next        = udp_reg;
        port_hi_ok_next = port_hi_ok_reg;
        port_ok_next    = port_ok_reg;
        nibble_next     = nibble_reg;
        flag_next       = flag_reg;
        seen_next       = seen_reg;

        if (pos_reg == PosEtherHi)
        begin
            ether_hi_next = b;
        end
        if (pos_reg == PosEtherLo)
        begin
            priority if (ether_full == EtherTypePtp)
            begin
                kind_next = KindL2;
            end
            else if (ether_full == EtherTypeIpv4)
            begin
                kind_next = KindIpv4;
            end
            else if (ether_full == EtherTypeIpv6)
            begin
                kind_next = KindIpv6;
            end
            else
            begin
                kind_next = KindNone;
            end
        end

        if (kind_reg == KindIpv4 || kind_reg == KindIpv6)
        begin
            if (pos_reg == proto_pos)
            begin
                udp_next = (b == ProtoUdp);
            end
            if (pos_reg == port_hi_pos)
            begin
                port_hi_ok_next = (b == PortEvent[15:8]);
            end
            if (pos_reg == port_lo_pos)
            begin
                port_ok_next = port_hi_ok_reg
                    && ((b == PortEvent[7:0]) || (b == PortGeneral[7:0]));
            end
        end

        // kind is only settled from byte 14 on, which is where headers start
        if (kind_reg != KindNone && pos_reg >= PosL2Start)
        begin
            if (pos_reg == start_pos)
            begin
                nibble_next = 4'(b & TypeMask);
            end
            if (pos_reg == start_pos + FlagOffset)
            begin
                flag_next = b[TwoStepBit];
            end
            if (pos_reg == start_pos + LastOffset && qualifies)
            begin
                seen_next = 1'b1;
            end
        end

        pos_next = (pos_reg < PosMax) ? pos_reg + 1'b1 : pos_reg;
    end

    assign info.header_seen   = seen_next;
    assign info.type_nibble   = nibble_next;
    assign info.two_step_flag = flag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            ether_hi_reg   <= '0;
            kind_reg       <= KindNone;
            udp_reg        <= 1'b0;
            port_hi_ok_reg <= 1'b0;
            port_ok_reg    <= 1'b0;
            nibble_reg     <= '0;
            flag_reg       <= 1'b0;
            seen_reg       <= 1'b0;
        end
        else if (step)
        begin
            if (item.frame_end)
            begin
                // clear for the next frame
                pos_reg        <= '0;
                ether_hi_reg   <= '0;
                kind_reg       <= KindNone;
                udp_reg        <= 1'b0;
                port_hi_ok_reg <= 1'b0;
                port_ok_reg    <= 1'b0;
                nibble_reg     <= '0;
                flag_reg       <= 1'b0;
                seen_reg       <= 1'b0;
            end
            else
            begin
                pos_reg        <= pos_next;
                ether_hi_reg   <= ether_hi_next;
                kind_reg       <= kind_next;
                udp_reg        <= udp_next;
                port_hi_ok_reg <= port_hi_ok_next;
                port_ok_reg    <= port_ok_next;
                nibble_reg     <= nibble_next;
                flag_reg       <= flag_next;
                seen_reg       <= seen_next;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ptc_result_stage.sv]
// Result stage: decodes control bits and holds the result transaction.
`timescale 1ns / 1ps
`default_nettype none

module ptc_result_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire ptc_pkg::frame_info_t info,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output ptc_pkg::out_item_t        out_item,
    output logic                      can_load
);
    import ptc_pkg::*;

    logic      valid_reg;
    out_item_t item_reg, item_next;

    always_comb
    begin
        item_next              = '0;
        item_next.send_request = 1'b1;
        if (info.header_seen)
        begin
            item_next.ptp_found = 1'b1;
            item_next.msg_type  = info.type_nibble;
            if (info.type_nibble == MsgSync)
            begin
                item_next.two_step     = info.two_step_flag;
                item_next.stamp_enable = info.two_step_flag;
                item_next.stamp_emit   = !info.two_step_flag;
            end
            else if (info.type_nibble == MsgDelayReq)
            begin
                item_next.stamp_enable = 1'b1;
                item_next.stamp_emit   = 1'b1;
            end
        end
    end

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ptp_tx_timestamp_classifier.sv]
// Top level: PTP transmit timestamp classifier, input register and result stage.
//
//   channel     dir  payload                                         when
//   frame_in    in   frame_byte[7:0], frame_end                      one per frame byte
//   result_out  out  ptp_found, msg_type[3:0], two_step,             one per frame,
//                    stamp_enable, stamp_emit, send_request          after final byte
//
// One byte is accepted per cycle unless a stalled result holds a final byte. A
// byte is registered in the input register, then updates the frame state; a final
// byte loads the result register, whose valid bit then presents the result. Reset
// clears all valid bits and frame state. A stalled result holds only a final
// byte in the input register, which drops ready until the result leaves.
`timescale 1ns / 1ps
`default_nettype none

module ptp_tx_timestamp_classifier (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ptc_stream_if.sink  frame_in,
    ptc_stream_if.source result_out
);
    import ptc_pkg::*;

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        advance;
    logic        can_load;
    logic        load;
    frame_info_t info;
    out_item_t   out_item;
    logic        out_valid;

    // a byte without frame_end produces no result and never waits
    assign advance = in_valid_reg && (!in_item_reg.frame_end || can_load);
    assign load    = advance && in_item_reg.frame_end;

    assign frame_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (frame_in.ready)
        begin
            in_valid_reg <= frame_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_in.ready && frame_in.valid)
        begin
            in_item_reg <= frame_in.payload;
        end
    end

    ptc_frame_tracker u_tracker (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_item_reg),
        .info  (info)
    );

    ptc_result_stage u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .info      (info),
        .out_ready (result_out.ready),
        .out_valid (out_valid),
        .out_item  (out_item),
        .can_load  (can_load)
    );

    assign result_out.valid   = out_valid;
    assign result_out.payload = out_item;

endmodule

`default_nettype wire

[verif/ptp_tx_timestamp_classifier_tb.sv]
// Testbench: random and directed frames through the PTP transmit classifier, checked per frame.
`timescale 1ns / 1ps

module ptp_tx_timestamp_classifier_tb;

    import ptc_pkg::*;

    typedef enum int {FrameL2, FrameV4, FrameV6, FrameNoise} frame_kind_e;
    typedef enum int {FaultNone, FaultEther, FaultProto, FaultPort} frame_fault_e;

    localparam int TargetBytes  = 1750;
    localparam int TargetFrames = 36;
    localparam int MaxFrameLen  = 200;
    localparam int IdlePercent  = 8;
    localparam int QuietFrom    = 1500;
    localparam int QuietTo      = 2500;

    logic clk = 1'b0;
    logic rst_n;

    ptc_stream_if #(.payload_t(in_item_t))  frame_in_if ();
    ptc_stream_if #(.payload_t(out_item_t)) result_if ();

    ptp_tx_timestamp_classifier uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame_in_if),
        .result_out (result_if)
    );

    in_item_t  tx_bytes [$];
    out_item_t expected_ctrl [$];

    int   total_bytes    = 0;
    int   total_frames   = 0;
    int   accepted_bytes = 0;
    int   frames_checked = 0;
    int   errors         = 0;
    int   cycle_cnt      = 0;
    logic in_fire        = 1'b0;

    // classifier state
    logic [6:0]  cls_pos   = '0;
    logic [15:0] cls_etype = '0;
    logic [7:0]  cls_proto = '0;
    logic [15:0] cls_port  = '0;
    logic [3:0]  cls_type  = '0;
    logic [7:0]  cls_flag  = '0;
    logic        cls_seen  = 1'b0;

    always #10 clk = ~clk;

    task automatic report_error(input string msg);
        $display("ERROR frame %0d: %s", frames_checked, msg);
        errors++;
    endtask

    task automatic compare_field(input string field, input int got, input int want);
        if (got != want)
        begin
            report_error($sformatf("%s got %0d, expected %0d", field, got, want));
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_ctrl.size() == 0)
        begin
            report_error($sformatf("result %p with no frame pending", got));
        end
        else
        begin
            want = expected_ctrl.pop_front();
            compare_field("ptp_found", got.ptp_found, want.ptp_found);
            compare_field("msg_type", got.msg_type, want.msg_type);
            compare_field("two_step", got.two_step, want.two_step);
            compare_field("stamp_enable", got.stamp_enable, want.stamp_enable);
            compare_field("stamp_emit", got.stamp_emit, want.stamp_emit);
            compare_field("send_request", got.send_request, want.send_request);
        end
        frames_checked++;
    endtask

    task automatic classify_byte(input in_item_t it);
        logic [6:0] pos;
        logic [6:0] start;
        logic       qualifies;
        out_item_t  res;
        pos = cls_pos;
        if (pos == PosEtherHi)
            cls_etype = {it.frame_byte, 8'h00};
        else if (pos == PosEtherLo)
            cls_etype[7:0] = it.frame_byte;

        if (cls_etype == EtherTypeIpv4)
        begin
            if (pos == PosV4Proto)
                cls_proto = it.frame_byte;
            else if (pos == PosV4PortHi)
                cls_port = {it.frame_byte, 8'h00};
            else if (pos == PosV4PortLo)
                cls_port[7:0] = it.frame_byte;
        end
        else if (cls_etype == EtherTypeIpv6)
        begin
            if (pos == PosV6Proto)
                cls_proto = it.frame_byte;
            else if (pos == PosV6PortHi)
                cls_port = {it.frame_byte, 8'h00};
            else if (pos == PosV6PortLo)
                cls_port[7:0] = it.frame_byte;
        end

        case (cls_etype)
            EtherTypePtp:  start = PosL2Start;
            EtherTypeIpv4: start = PosV4Start;
            EtherTypeIpv6: start = PosV6Start;
            default:       start = '0;
        endcase
        qualifies = (cls_etype == EtherTypePtp) ||
                    ((cls_etype == EtherTypeIpv4 || cls_etype == EtherTypeIpv6) &&
                     cls_proto == ProtoUdp &&
                     (cls_port == PortEvent || cls_port == PortGeneral));

        if (start != '0 && pos >= PosL2Start)
        begin
            if (pos == start)
                cls_type = it.frame_byte[3:0];
            else if (pos == start + FlagOffset)
                cls_flag = it.frame_byte;
            if (pos == start + LastOffset && qualifies)
                cls_seen = 1'b1;
        end

        // saturate the position so long frames cannot wrap into the header window
        if (pos != PosMax)
            cls_pos = pos + 7'd1;

        if (it.frame_end)
        begin
            res = '0;
            res.send_request = 1'b1;
            if (cls_seen)
            begin
                res.ptp_found = 1'b1;
                res.msg_type  = cls_type;
                if (cls_type == MsgSync)
                begin
                    res.two_step     = cls_flag[TwoStepBit];
                    res.stamp_enable = cls_flag[TwoStepBit];
                    res.stamp_emit   = !cls_flag[TwoStepBit];
                end
                else if (cls_type == MsgDelayReq)
                begin
                    res.stamp_enable = 1'b1;
                    res.stamp_emit   = 1'b1;
                end
            end
            expected_ctrl.push_back(res);
            cls_pos   = '0;
            cls_etype = '0;
            cls_proto = '0;
            cls_port  = '0;
            cls_type  = '0;
            cls_flag  = '0;
            cls_seen  = 1'b0;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        in_item_t it;
        it.frame_byte = b;
        it.frame_end  = last;
        tx_bytes.push_back(it);
        total_bytes++;
        if (last)
            total_frames++;
    endtask

    task automatic queue_frame(input frame_kind_e kind, input int len,
                               input logic [3:0] mtype, input logic two,
                               input frame_fault_e fault);
        logic [7:0]  fb [0:MaxFrameLen-1];
        logic [15:0] etype;
        logic [15:0] port;
        int          start;
        for (int i = 0; i < MaxFrameLen; i++)
            fb[i] = 8'($urandom);
        if (kind != FrameNoise)
        begin
            case (kind)
                FrameL2: begin etype = EtherTypePtp;  start = PosL2Start; end
                FrameV4: begin etype = EtherTypeIpv4; start = PosV4Start; end
                default: begin etype = EtherTypeIpv6; start = PosV6Start; end
            endcase
            if (fault == FaultEther)
                etype = 16'($urandom);
            port = $urandom_range(0, 1) ? PortEvent : PortGeneral;
            if (fault == FaultPort)
                port = 16'($urandom);
            fb[PosEtherHi] = etype[15:8];
            fb[PosEtherLo] = etype[7:0];
            if (kind == FrameV4)
            begin
                fb[PosV4Proto]  = (fault == FaultProto) ? 8'($urandom) : ProtoUdp;
                fb[PosV4PortHi] = port[15:8];
                fb[PosV4PortLo] = port[7:0];
            end
            else if (kind == FrameV6)
            begin
                fb[PosV6Proto]  = (fault == FaultProto) ? 8'($urandom) : ProtoUdp;
                fb[PosV6PortHi] = port[15:8];
                fb[PosV6PortLo] = port[7:0];
            end
            fb[start][3:0]                  = mtype;
            fb[start + FlagOffset][TwoStepBit] = two;
        end
        for (int i = 0; i < len; i++)
            push_byte(fb[i], i == len - 1);
    endtask

    task automatic queue_random_frame(input int idx);
        frame_kind_e  kind;
        frame_fault_e fault;
        logic [3:0]   mtype;
        logic         two;
        int           hdr_end;
        int           len;
        int           pick;
        pick = $urandom_range(0, 99);
        kind = pick < 30 ? FrameL2 : pick < 60 ? FrameV4 : pick < 90 ? FrameV6 : FrameNoise;
        pick = $urandom_range(0, 3);
        mtype = pick == 0 ? MsgSync : pick == 1 ? MsgDelayReq : 4'($urandom);
        two   = 1'($urandom);
        fault = ($urandom_range(0, 99) < 80) ? FaultNone
                                             : frame_fault_e'($urandom_range(1, 3));
        // walk each encapsulation with Sync (both flag values), Delay_Req and type F, using exact-length frames
        if (idx < 12)
        begin
            kind  = frame_kind_e'(idx % 3);
            fault = FaultNone;
            case (idx / 3)
                0:       begin mtype = MsgSync; two = 1'b1; end
                1:       begin mtype = MsgSync; two = 1'b0; end
                2:       mtype = MsgDelayReq;
                default: mtype = 4'hF;
            endcase
        end
        hdr_end = (kind == FrameL2) ? PosL2Start + 34 :
                  (kind == FrameV4) ? PosV4Start + 34 : PosV6Start + 34;
        pick = (idx < 12) ? 25 : $urandom_range(0, 99);
        if (kind == FrameNoise)
            len = $urandom_range(1, 80);
        else if (pick < 20)
            len = $urandom_range(1, hdr_end - 1);
        else if (pick < 30)
            len = hdr_end;
        else if (pick < 35)
            len = $urandom_range(128, MaxFrameLen);
        else
            len = hdr_end + $urandom_range(0, 12);
        queue_frame(kind, len, mtype, two, fault);
    endtask

    // driver: hold payload until accepted, then advance or idle
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            cycle_cnt <= cycle_cnt + 1;
            if (!frame_in_if.valid || in_fire)
            begin
                if (tx_bytes.size() > 0 &&
                    ((cycle_cnt >= QuietFrom && cycle_cnt < QuietTo) ||
                     $urandom_range(0, 99) >= IdlePercent))
                begin
                    frame_in_if.valid   <= 1'b1;
                    frame_in_if.payload <= tx_bytes.pop_front();
                end
                else
                begin
                    frame_in_if.valid <= 1'b0;
                end
            end
            result_if.ready <= (cycle_cnt >= QuietFrom && cycle_cnt < QuietTo) ||
                               ($urandom_range(0, 99) >= IdlePercent);
        end
    end

    // monitor: check results before predicting, since a result always belongs to an older frame
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= frame_in_if.valid && frame_in_if.ready;
            if (result_if.valid && result_if.ready)
                check_result(result_if.payload);
            if (frame_in_if.valid && frame_in_if.ready)
            begin
                classify_byte(frame_in_if.payload);
                accepted_bytes++;
            end
        end
    end

    initial
    begin
        int idx;
        rst_n               = 1'b0;
        frame_in_if.valid   = 1'b0;
        frame_in_if.payload = '0;
        result_if.ready     = 1'b0;

        // single-byte frames and frames that end before any header
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        for (int i = 0; i < 12; i++)
            push_byte(8'hFF, 1'b0);
        push_byte(EtherTypePtp[15:8], 1'b0);
        push_byte(EtherTypePtp[7:0], 1'b1);
        for (int i = 0; i < 8; i++)
            push_byte(8'h00, i == 7);

        idx = 0;
        while (total_bytes < TargetBytes || total_frames < TargetFrames)
        begin
            queue_random_frame(idx);
            idx++;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (accepted_bytes == total_bytes);
        wait (expected_ctrl.size() == 0);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("** ptp_tx_timestamp_classifier: PASSED **");
        else
            $display("** ptp_tx_timestamp_classifier: FAILED **");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("ERROR: run timed out");
        $display("** ptp_tx_timestamp_classifier: FAILED **");
        $finish;
    end

endmodule

[ptp_tx_timestamp_classifier.f]
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_stream_if.sv
hw/rtl/ptc_frame_tracker.sv
hw/rtl/ptc_result_stage.sv
hw/rtl/ptp_tx_timestamp_classifier.sv
verif/ptp_tx_timestamp_classifier_tb.sv
